[hw/rtl/disk_pair_elastic_collision_assert.svh]
// ----------------------------------------------------------------------------
// disk_pair_elastic_collision_assert.svh
// Assertion macros shared by the disk pair collision checker.
// ----------------------------------------------------------------------------
`ifndef DISK_PAIR_ELASTIC_COLLISION_ASSERT_SVH
`define DISK_PAIR_ELASTIC_COLLISION_ASSERT_SVH

// same-cycle implication, off during reset
`define DPEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpec: assertion failed");

// next-cycle implication, off during reset
`define DPEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpec: assertion failed");

// next-cycle implication that also covers the reset cycles
`define DPEC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpec: assertion failed");

`endif

[hw/rtl/dpec_pkg.sv]
// ----------------------------------------------------------------------------
// dpec_pkg
// Types, pipeline depths and helpers for the disk pair collision pipeline.
// ----------------------------------------------------------------------------
package dpec_pkg;

  localparam int SQ_ST  = 17;   // root bits, one per stage
  localparam int ND_ST  = 17;   // unit normal quotient bits
  localparam int MD_ST  = 43;   // mass exchange quotient bits
  localparam int LAT    = 3 + SQ_ST + ND_ST + 5 + MD_ST + 3;

  localparam logic signed [29:0] SAT_HI = 30'sd8388607;
  localparam logic signed [29:0] SAT_LO = -30'sd8388608;

  // item as it runs through the front half
  typedef struct packed {
    logic signed [23:0] pa_x;
    logic signed [23:0] pa_y;
    logic signed [23:0] va_x;
    logic signed [23:0] va_y;
    logic signed [23:0] pb_x;
    logic signed [23:0] pb_y;
    logic signed [23:0] vb_x;
    logic signed [23:0] vb_y;
    logic [11:0]        ma;
    logic [11:0]        mb;
    logic [16:0]        sr;
    logic               hit;
    logic               nz;
    logic               sgn_x;
    logic               sgn_y;
    logic [16:0]        adx;
    logic [16:0]        ady;
  } base_t;

  typedef struct packed {
    base_t       b;
    logic [16:0] d;
  } nd_t;

  // item after position correction, around the mass exchange divider
  typedef struct packed {
    logic signed [23:0] pa_x;
    logic signed [23:0] pa_y;
    logic signed [23:0] pb_x;
    logic signed [23:0] pb_y;
    logic signed [23:0] va_x;
    logic signed [23:0] va_y;
    logic signed [23:0] vb_x;
    logic signed [23:0] vb_y;
    logic [16:0]        qx;
    logic [16:0]        qy;
    logic               sgn_x;
    logic               sgn_y;
    logic [41:0]        adelta;
    logic               sdelta;
    logic               vok;
    logic               hit;
    logic [11:0]        mb;
    logic [12:0]        msum;
  } mid_t;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    logic signed [23:0] r;
    if (v > SAT_HI) r = SAT_HI[23:0];
    else if (v < SAT_LO) r = SAT_LO[23:0];
    else r = v[23:0];
    return r;
  endfunction

endpackage

[hw/rtl/dpec_isqrt.sv]
// ----------------------------------------------------------------------------
// dpec_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module dpec_isqrt #(
  parameter int RW = 34
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RW-1:0]     rad,
  output logic [RW/2-1:0]   root
);

  localparam int QW = RW / 2;
  localparam int XW = RW + 1;

  logic [XW-1:0] rem_r  [QW-1];
  logic [QW-1:0] root_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic [XW-1:0] rem_in;
    logic [XW-1:0] trial;
    logic [QW-1:0] root_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, rad};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = (XW'(root_in) << (B + 1)) + (XW'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (root_in | (QW'(1) << B)) : root_in;
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_r[QW-1];

endmodule

[hw/rtl/dpec_udiv.sv]
// ----------------------------------------------------------------------------
// dpec_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Needs num < den * 2^QW.
// ----------------------------------------------------------------------------
module dpec_udiv #(
  parameter int NW = 33,
  parameter int DW = 17,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = NW + DW;

  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = CW'(den_in) << B;
    assign diff  = CW'(rem_in) - trial;
    assign take  = CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[NW-1:0] : rem_in;
        quo_r[k] <= take ? (quo_in | (QW'(1) << B)) : quo_in;
      end
    end

    if (k < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QW-1];
  assign rem = rem_r[QW-1][DW-1:0];

endmodule

[hw/rtl/disk_pair_elastic_collision.sv]
// One disk pair per cycle sustained, except while a stalled result holds the pipeline.
// Depth is set by the bit-per-stage units: 17-stage square root, 17-stage normal
// divider and 43-stage mass exchange divider, plus 11 arithmetic stages.
// The whole pipeline holds while a result waits and out_ready is low.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// disk_pair_elastic_collision
// Overlap test, push-apart and elastic normal velocity exchange of two disks.
// ----------------------------------------------------------------------------
module disk_pair_elastic_collision (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_pos_a_x,
  input  logic signed [23:0] in_pos_a_y,
  input  logic signed [23:0] in_vel_a_x,
  input  logic signed [23:0] in_vel_a_y,
  input  logic [11:0]        in_mass_a,
  input  logic [15:0]        in_radius_a,
  input  logic signed [23:0] in_pos_b_x,
  input  logic signed [23:0] in_pos_b_y,
  input  logic signed [23:0] in_vel_b_x,
  input  logic signed [23:0] in_vel_b_y,
  input  logic [11:0]        in_mass_b,
  input  logic [15:0]        in_radius_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_collided,
  output logic signed [23:0] out_new_pos_a_x,
  output logic signed [23:0] out_new_pos_a_y,
  output logic signed [23:0] out_new_vel_a_x,
  output logic signed [23:0] out_new_vel_a_y,
  output logic signed [23:0] out_new_pos_b_x,
  output logic signed [23:0] out_new_pos_b_y,
  output logic signed [23:0] out_new_vel_b_x,
  output logic signed [23:0] out_new_vel_b_y
);

  localparam int LAT = dpec_pkg::LAT;
  localparam int SQ  = dpec_pkg::SQ_ST;
  localparam int ND  = dpec_pkg::ND_ST;
  localparam int MD  = dpec_pkg::MD_ST;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- stage 1: differences ----------------
  dpec_pkg::base_t    s1_nxt;
  logic signed [24:0] dx, dy, adx_f, ady_f;
  dpec_pkg::base_t    s1_b_r;
  logic signed [24:0] s1_dx_r, s1_dy_r;

  assign dx    = 25'(in_pos_a_x) - 25'(in_pos_b_x);
  assign dy    = 25'(in_pos_a_y) - 25'(in_pos_b_y);
  assign adx_f = dx[24] ? -dx : dx;
  assign ady_f = dy[24] ? -dy : dy;

  always_comb begin
    s1_nxt       = '0;
    s1_nxt.pa_x  = in_pos_a_x;
    s1_nxt.pa_y  = in_pos_a_y;
    s1_nxt.va_x  = in_vel_a_x;
    s1_nxt.va_y  = in_vel_a_y;
    s1_nxt.pb_x  = in_pos_b_x;
    s1_nxt.pb_y  = in_pos_b_y;
    s1_nxt.vb_x  = in_vel_b_x;
    s1_nxt.vb_y  = in_vel_b_y;
    s1_nxt.ma    = in_mass_a;
    s1_nxt.mb    = in_mass_b;
    s1_nxt.sr    = 17'(in_radius_a) + 17'(in_radius_b);
    s1_nxt.sgn_x = dx[24];
    s1_nxt.sgn_y = dy[24];
    // only meaningful on a hit, where |dx| <= d < 2^17
    s1_nxt.adx   = adx_f[16:0];
    s1_nxt.ady   = ady_f[16:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_b_r  <= s1_nxt;
      s1_dx_r <= dx;
      s1_dy_r <= dy;
    end
  end

  // ---------------- stage 2: squares ----------------
  logic signed [49:0] dx2, dy2;
  dpec_pkg::base_t    s2_b_r;
  logic [49:0]        s2_dx2_r, s2_dy2_r;
  logic [33:0]        s2_sr2_r;

  assign dx2 = 50'(s1_dx_r) * 50'(s1_dx_r);
  assign dy2 = 50'(s1_dy_r) * 50'(s1_dy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_b_r   <= s1_b_r;
      s2_dx2_r <= dx2;
      s2_dy2_r <= dy2;
      s2_sr2_r <= 34'(s1_b_r.sr) * 34'(s1_b_r.sr);
    end
  end

  // ---------------- stage 3: overlap test ----------------
  logic [50:0]     d2;
  logic            hit;
  dpec_pkg::base_t s3_nxt;
  dpec_pkg::base_t s3_b_r;
  logic [33:0]     s3_rad_r;

  assign d2  = 51'(s2_dx2_r) + 51'(s2_dy2_r);
  assign hit = d2 <= 51'(s2_sr2_r);

  always_comb begin
    s3_nxt     = s2_b_r;
    s3_nxt.hit = hit;
    s3_nxt.nz  = d2 != '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_b_r   <= s3_nxt;
      s3_rad_r <= hit ? d2[33:0] : '0;
    end
  end

  // ---------------- distance ----------------
  logic [16:0]     root;
  dpec_pkg::base_t sq_dly_r [SQ];

  dpec_isqrt #(.RW(34)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s3_rad_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sq_dly_r[0] <= s3_b_r;
      for (int i = 1; i < SQ; i++) sq_dly_r[i] <= sq_dly_r[i-1];
    end
  end

  // ---------------- unit normal ----------------
  logic [16:0]   qx, qy;
  logic [16:0]   nd_rx, nd_ry;
  dpec_pkg::nd_t nd_dly_r [ND];

  dpec_udiv #(.NW(33), .DW(17), .QW(17)) u_div_nx (
    .clk (clk),
    .en  (en),
    .num ({sq_dly_r[SQ-1].adx, 16'd0}),
    .den (root),
    .quo (qx),
    .rem (nd_rx)
  );

  dpec_udiv #(.NW(33), .DW(17), .QW(17)) u_div_ny (
    .clk (clk),
    .en  (en),
    .num ({sq_dly_r[SQ-1].ady, 16'd0}),
    .den (root),
    .quo (qy),
    .rem (nd_ry)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nd_dly_r[0] <= '{b: sq_dly_r[SQ-1], d: root};
      for (int i = 1; i < ND; i++) nd_dly_r[i] <= nd_dly_r[i-1];
    end
  end

  // ---------------- stage 4: signed normal, penetration ----------------
  dpec_pkg::base_t    s4_b_r;
  logic signed [17:0] s4_nx_r, s4_ny_r;
  logic [16:0]        s4_qx_r, s4_qy_r, s4_pen_r;
  logic signed [17:0] nx_s, ny_s;

  assign nx_s = nd_dly_r[ND-1].b.sgn_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ny_s = nd_dly_r[ND-1].b.sgn_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_ff @(posedge clk) begin
    if (en) begin
      s4_b_r   <= nd_dly_r[ND-1].b;
      s4_nx_r  <= nx_s;
      s4_ny_r  <= ny_s;
      s4_qx_r  <= qx;
      s4_qy_r  <= qy;
      s4_pen_r <= nd_dly_r[ND-1].b.sr - nd_dly_r[ND-1].d;
    end
  end

  // ---------------- stage 5: products ----------------
  dpec_pkg::base_t    s5_b_r;
  logic [16:0]        s5_qx_r, s5_qy_r;
  logic [33:0]        s5_ppx_r, s5_ppy_r;
  logic signed [41:0] s5_tax_r, s5_tay_r, s5_tbx_r, s5_tby_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_b_r   <= s4_b_r;
      s5_qx_r  <= s4_qx_r;
      s5_qy_r  <= s4_qy_r;
      s5_ppx_r <= 34'(s4_pen_r) * 34'(s4_qx_r);
      s5_ppy_r <= 34'(s4_pen_r) * 34'(s4_qy_r);
      s5_tax_r <= 42'(s4_nx_r) * 42'(s4_b_r.va_x);
      s5_tay_r <= 42'(s4_ny_r) * 42'(s4_b_r.va_y);
      s5_tbx_r <= 42'(s4_nx_r) * 42'(s4_b_r.vb_x);
      s5_tby_r <= 42'(s4_ny_r) * 42'(s4_b_r.vb_y);
    end
  end

  // ---------------- stage 6: push apart, normal speeds ----------------
  logic               pok;
  logic [16:0]        pmx, pmy;
  logic signed [17:0] sx, sy;
  logic signed [42:0] ua, ub;
  logic signed [43:0] dl, adl;
  logic [12:0]        msum;
  dpec_pkg::mid_t     s6_nxt;
  dpec_pkg::mid_t     s6_r;

  assign pok  = s5_b_r.hit && s5_b_r.nz;
  assign pmx  = s5_ppx_r[33:17];
  assign pmy  = s5_ppy_r[33:17];
  assign sx   = !pok ? '0 : (s5_b_r.sgn_x ? -$signed({1'b0, pmx}) : $signed({1'b0, pmx}));
  assign sy   = !pok ? '0 : (s5_b_r.sgn_y ? -$signed({1'b0, pmy}) : $signed({1'b0, pmy}));
  assign ua   = 43'(s5_tax_r) + 43'(s5_tay_r);
  assign ub   = 43'(s5_tbx_r) + 43'(s5_tby_r);
  assign dl   = 44'(ub) - 44'(ua);
  assign adl  = dl[43] ? -dl : dl;
  assign msum = 13'(s5_b_r.ma) + 13'(s5_b_r.mb);

  always_comb begin
    s6_nxt.pa_x   = dpec_pkg::sat24(30'(s5_b_r.pa_x) + 30'(sx));
    s6_nxt.pa_y   = dpec_pkg::sat24(30'(s5_b_r.pa_y) + 30'(sy));
    s6_nxt.pb_x   = dpec_pkg::sat24(30'(s5_b_r.pb_x) - 30'(sx));
    s6_nxt.pb_y   = dpec_pkg::sat24(30'(s5_b_r.pb_y) - 30'(sy));
    s6_nxt.va_x   = s5_b_r.va_x;
    s6_nxt.va_y   = s5_b_r.va_y;
    s6_nxt.vb_x   = s5_b_r.vb_x;
    s6_nxt.vb_y   = s5_b_r.vb_y;
    s6_nxt.qx     = s5_qx_r;
    s6_nxt.qy     = s5_qy_r;
    s6_nxt.sgn_x  = s5_b_r.sgn_x;
    s6_nxt.sgn_y  = s5_b_r.sgn_y;
    s6_nxt.adelta = adl[41:0];
    s6_nxt.sdelta = dl[43];
    s6_nxt.vok    = pok && (msum != '0);
    s6_nxt.hit    = s5_b_r.hit;
    s6_nxt.mb     = s5_b_r.mb;
    s6_nxt.msum   = msum;
  end

  always_ff @(posedge clk) begin
    if (en) s6_r <= s6_nxt;
  end

  // ---------------- stages 7, 8: 2*mb*|delta| ----------------
  dpec_pkg::mid_t s7_r, s8_r;
  logic [33:0]    s7_pl_r, s7_ph_r;
  logic [54:0]    s8_num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r     <= s6_r;
      s7_pl_r  <= 34'({s6_r.mb, 1'b0}) * 34'(s6_r.adelta[20:0]);
      s7_ph_r  <= 34'({s6_r.mb, 1'b0}) * 34'(s6_r.adelta[41:21]);
      s8_r     <= s7_r;
      s8_num_r <= (55'(s7_ph_r) << 21) + 55'(s7_pl_r);
    end
  end

  // ---------------- mass exchange divide ----------------
  logic [42:0]    mq;
  logic [12:0]    mrem;
  dpec_pkg::mid_t md_dly_r [MD];

  dpec_udiv #(.NW(55), .DW(13), .QW(43)) u_div_m (
    .clk (clk),
    .en  (en),
    .num (s8_num_r),
    .den (s8_r.msum),
    .quo (mq),
    .rem (mrem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      md_dly_r[0] <= s8_r;
      for (int i = 1; i < MD; i++) md_dly_r[i] <= md_dly_r[i-1];
    end
  end

  // ---------------- stage 9: exchange terms ----------------
  // 2*ma*|delta|/M = 2|delta| - ceil(2*mb*|delta|/M)
  dpec_pkg::mid_t s9_r;
  logic [42:0]    s9_dua_r, s9_dub_r;
  logic [42:0]    dub;

  assign dub = {md_dly_r[MD-1].adelta, 1'b0} - mq - 43'(mrem != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_r     <= md_dly_r[MD-1];
      s9_dua_r <= md_dly_r[MD-1].vok ? mq  : '0;
      s9_dub_r <= md_dly_r[MD-1].vok ? dub : '0;
    end
  end

  // ---------------- stage 10: normal times exchange ----------------
  // lanes: A.x, A.y, B.x, B.y
  logic [16:0]    nsel [4];
  logic [42:0]    dsel [4];
  logic [3:0]     sg;
  dpec_pkg::mid_t s10_r;
  logic [38:0]    s10_lo_r [4];
  logic [37:0]    s10_hi_r [4];
  logic [3:0]     s10_sg_r;

  always_comb begin
    nsel[0] = s9_r.qx;  dsel[0] = s9_dua_r;
    nsel[1] = s9_r.qy;  dsel[1] = s9_dua_r;
    nsel[2] = s9_r.qx;  dsel[2] = s9_dub_r;
    nsel[3] = s9_r.qy;  dsel[3] = s9_dub_r;
    sg[0]   = s9_r.sgn_x ^ s9_r.sdelta;
    sg[1]   = s9_r.sgn_y ^ s9_r.sdelta;
    sg[2]   = s9_r.sgn_x ^ ~s9_r.sdelta;
    sg[3]   = s9_r.sgn_y ^ ~s9_r.sdelta;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_r    <= s9_r;
      s10_sg_r <= sg;
      for (int i = 0; i < 4; i++) begin
        s10_lo_r[i] <= 39'(nsel[i]) * 39'(dsel[i][21:0]);
        s10_hi_r[i] <= 38'(nsel[i]) * 38'(dsel[i][42:22]);
      end
    end
  end

  // ---------------- stage 11: velocity update, output register ----------------
  logic signed [23:0] vin  [4];
  logic signed [23:0] vnew [4];
  logic [59:0]        full [4];
  logic [27:0]        dmag [4];
  logic signed [28:0] dv   [4];

  always_comb begin
    vin[0] = s10_r.va_x;
    vin[1] = s10_r.va_y;
    vin[2] = s10_r.vb_x;
    vin[3] = s10_r.vb_y;
    for (int i = 0; i < 4; i++) begin
      full[i] = (60'(s10_hi_r[i]) << 22) + 60'(s10_lo_r[i]);
      dmag[i] = full[i][59:32];
      dv[i]   = s10_sg_r[i] ? -$signed({1'b0, dmag[i]}) : $signed({1'b0, dmag[i]});
      vnew[i] = dpec_pkg::sat24(30'(vin[i]) + 30'(dv[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_collided    <= s10_r.hit;
      out_new_pos_a_x <= s10_r.pa_x;
      out_new_pos_a_y <= s10_r.pa_y;
      out_new_pos_b_x <= s10_r.pb_x;
      out_new_pos_b_y <= s10_r.pb_y;
      out_new_vel_a_x <= vnew[0];
      out_new_vel_a_y <= vnew[1];
      out_new_vel_b_x <= vnew[2];
      out_new_vel_b_y <= vnew[3];
    end
  end

endmodule

[hw/rtl/dpec_checker.sv]
// ----------------------------------------------------------------------------
// dpec_checker
// Port-level checks on the disk pair collision pipeline, bound to the top.
// ----------------------------------------------------------------------------
`include "disk_pair_elastic_collision_assert.svh"

module dpec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_collided,
  input logic signed [23:0] out_new_pos_a_x,
  input logic signed [23:0] out_new_pos_a_y,
  input logic signed [23:0] out_new_vel_a_x,
  input logic signed [23:0] out_new_vel_a_y,
  input logic signed [23:0] out_new_pos_b_x,
  input logic signed [23:0] out_new_pos_b_y,
  input logic signed [23:0] out_new_vel_b_x,
  input logic signed [23:0] out_new_vel_b_y
);

  // whole result payload as one vector
  logic [192:0] res_w;

  assign res_w = {out_collided,
                  out_new_pos_a_x, out_new_pos_a_y, out_new_vel_a_x, out_new_vel_a_y,
                  out_new_pos_b_x, out_new_pos_b_y, out_new_vel_b_x, out_new_vel_b_y};

  // a pending result is never dropped
  `DPEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a pending result does not change under stall
  `DPEC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(res_w))

  // input side stalls exactly when the output register holds an untaken result
  `DPEC_ASSERT_NOW(a_ready_link, 1'b1, in_ready == (out_ready || !out_valid))

  // reset empties the pipeline
  `DPEC_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)

endmodule

bind disk_pair_elastic_collision dpec_checker u_dpec_checker (.*);
